>>> rtl/frx_pkg.sv
// Shared types and constants for the framed packet receive ring buffer.
// Used by frx_front, frx_back and the top level; no dependencies of its own.
package frx_pkg;

  // RING_DEPTH is a power of two so that pointers wrap naturally
  localparam int RING_DEPTH  = 1024;
  localparam int FRAME_BYTES = 1024;
  localparam int HDR_SIZE    = 4;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int LEN_MAX     = ((RING_DEPTH < FRAME_BYTES) ? RING_DEPTH : FRAME_BYTES)
                               - HDR_SIZE;
  localparam int REM_W       = $clog2(LEN_MAX + 1);
  localparam logic [7:0] SIG_BYTE = 8'hFF;

  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_POP   = 2'd1;
  localparam logic [1:0] CMD_FLUSH = 2'd2;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_POP,
    OP_FLUSH,
    OP_START,
    OP_BYTE
  } op_kind_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEN_LO,
    PH_LEN_HI,
    PH_SIG2,
    PH_PAYLOAD
  } phase_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_ACCEPT  = 3'd1,
    ST_DROPPED = 3'd2,
    ST_BAD_SIG = 3'd3,
    ST_BAD_LEN = 3'd4
  } status_t;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] rx_byte;
    logic       frame_start;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        read_valid;
    logic [9:0]  fill_level;
    logic [2:0]  packet_status;
    logic        blocked;
    logic        resumed;
    logic [31:0] drop_total;
  } out_item_t;

  // decoded request handed from front to back
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] data;
    logic       is_sig;
  } op_t;

endpackage

>>> rtl/frx_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module frx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/frx_front.sv
// Front end: accepts input requests, decodes them into ops and queues them.
// Depends on frx_pkg.
module frx_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  frx_pkg::in_item_t in_data,
  output logic             q_valid,
  output frx_pkg::op_t     q_op,
  input  logic             q_pop
);

  frx_pkg::op_t q_r [2];
  logic         wr_ptr_r, wr_ptr_nxt;
  logic         rd_ptr_r, rd_ptr_nxt;
  logic [1:0]   count_r, count_nxt;
  frx_pkg::op_t dec_op;
  logic         push;

  always_comb begin
    dec_op.data   = in_data.rx_byte;
    dec_op.is_sig = (in_data.rx_byte == frx_pkg::SIG_BYTE);
    unique case (in_data.command)
      frx_pkg::CMD_FRAME: dec_op.kind = in_data.frame_start ? frx_pkg::OP_START
                                                            : frx_pkg::OP_BYTE;
      frx_pkg::CMD_POP:   dec_op.kind = frx_pkg::OP_POP;
      frx_pkg::CMD_FLUSH: dec_op.kind = frx_pkg::OP_FLUSH;
      default:            dec_op.kind = frx_pkg::OP_NOP;
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_op     = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= dec_op;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty request queue");

endmodule

>>> rtl/frx_back.sv
// Back end: header parser, ring pointers, drop accounting and result stage.
// Depends on frx_pkg and frx_ram.
module frx_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  frx_pkg::op_t       q_op,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output frx_pkg::out_item_t out_data
);

  localparam int PW = frx_pkg::PTR_W;
  localparam int RW = frx_pkg::REM_W;

  frx_pkg::phase_t  phase_r, phase_nxt;
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [PW-1:0]    wptr_r, wptr_nxt;
  logic [RW-1:0]    rem_r, rem_nxt;
  logic [7:0]       len_lo_r, len_lo_nxt;
  logic [15:0]      plen_r, plen_nxt;
  logic [31:0]      drop_r, drop_nxt;
  logic             blocked_r, blocked_nxt;

  logic             s2_valid_r, s2_valid_nxt;
  logic             s2_rv_r;
  logic [9:0]       s2_fill_r;
  frx_pkg::status_t s2_status_r;
  logic             s2_blocked_r;
  logic             s2_resumed_r;
  logic [31:0]      s2_drops_r;

  logic             fire;
  logic             rd_en, wr_en, rv, resumed;
  frx_pkg::status_t status;
  logic [31:0]      shown;
  logic [PW-1:0]    fill_now, fill_after;
  logic [PW:0]      free_now;
  logic [7:0]       ram_rdata;

  assign fire  = q_valid && (!s2_valid_r || !out_stall);
  assign q_pop = fire;

  assign fill_now = head_r - tail_r;
  assign free_now = (PW+1)'(frx_pkg::RING_DEPTH) - {1'b0, fill_now};

  always_comb begin
    phase_nxt   = phase_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    wptr_nxt    = wptr_r;
    rem_nxt     = rem_r;
    len_lo_nxt  = len_lo_r;
    plen_nxt    = plen_r;
    drop_nxt    = drop_r;
    blocked_nxt = blocked_r;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    rv          = 1'b0;
    resumed     = 1'b0;
    status      = frx_pkg::ST_NONE;
    shown       = drop_r;
    if (fire) begin
      unique case (q_op.kind)
        frx_pkg::OP_POP: begin
          if (head_r != tail_r) begin
            rd_en    = 1'b1;
            rv       = 1'b1;
            tail_nxt = tail_r + 1'b1;
          end
        end
        frx_pkg::OP_FLUSH: tail_nxt = head_r;
        frx_pkg::OP_START: begin
          // abandon whatever was in progress
          rem_nxt = '0;
          if (q_op.is_sig) begin
            phase_nxt = frx_pkg::PH_LEN_LO;
          end else begin
            phase_nxt = frx_pkg::PH_IDLE;
            status    = frx_pkg::ST_BAD_SIG;
          end
        end
        frx_pkg::OP_BYTE: begin
          unique case (phase_r)
            frx_pkg::PH_LEN_LO: begin
              len_lo_nxt = q_op.data;
              phase_nxt  = frx_pkg::PH_LEN_HI;
            end
            frx_pkg::PH_LEN_HI: begin
              plen_nxt  = {q_op.data, len_lo_r};
              phase_nxt = frx_pkg::PH_SIG2;
            end
            frx_pkg::PH_SIG2: begin
              phase_nxt = frx_pkg::PH_IDLE;
              if (!q_op.is_sig) begin
                status = frx_pkg::ST_BAD_SIG;
              end else if (plen_r == 16'd0 || plen_r > 16'(frx_pkg::LEN_MAX)) begin
                status = frx_pkg::ST_BAD_LEN;
              end else if (17'(plen_r) < 17'(free_now)) begin
                wptr_nxt  = head_r;
                rem_nxt   = RW'(plen_r);
                phase_nxt = frx_pkg::PH_PAYLOAD;
              end else begin
                if (drop_r != '1) begin
                  drop_nxt = drop_r + 32'd1;
                end
                shown       = drop_nxt;
                blocked_nxt = 1'b1;
                status      = frx_pkg::ST_DROPPED;
              end
            end
            frx_pkg::PH_PAYLOAD: begin
              wr_en    = 1'b1;
              wptr_nxt = wptr_r + 1'b1;
              rem_nxt  = rem_r - 1'b1;
              if (rem_r == RW'(1)) begin
                // last payload byte: commit the packet
                head_nxt  = wptr_r + 1'b1;
                phase_nxt = frx_pkg::PH_IDLE;
                status    = frx_pkg::ST_ACCEPT;
                if (blocked_r) begin
                  resumed     = 1'b1;
                  blocked_nxt = 1'b0;
                  drop_nxt    = '0;
                end
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    fill_after   = head_nxt - tail_nxt;
    s2_valid_nxt = fire || (s2_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= frx_pkg::PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      wptr_r     <= '0;
      rem_r      <= '0;
      len_lo_r   <= '0;
      plen_r     <= '0;
      drop_r     <= '0;
      blocked_r  <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      wptr_r     <= wptr_nxt;
      rem_r      <= rem_nxt;
      len_lo_r   <= len_lo_nxt;
      plen_r     <= plen_nxt;
      drop_r     <= drop_nxt;
      blocked_r  <= blocked_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  // result stage; popped data arrives from the RAM read register alongside
  always_ff @(posedge clk) begin
    if (fire) begin
      s2_rv_r      <= rv;
      s2_fill_r    <= 10'(fill_after);
      s2_status_r  <= status;
      s2_blocked_r <= blocked_nxt;
      s2_resumed_r <= resumed;
      s2_drops_r   <= shown;
    end
  end

  frx_ram #(
    .WIDTH(8),
    .DEPTH(frx_pkg::RING_DEPTH)
  ) u_ring (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wptr_r),
    .wr_data(q_op.data),
    .rd_en  (rd_en),
    .rd_addr(tail_r),
    .rd_data(ram_rdata)
  );

  assign out_valid = s2_valid_r;
  always_comb begin
    out_data.read_data     = s2_rv_r ? ram_rdata : 8'd0;
    out_data.read_valid    = s2_rv_r;
    out_data.fill_level    = s2_fill_r;
    out_data.packet_status = 3'(s2_status_r);
    out_data.blocked       = s2_blocked_r;
    out_data.resumed       = s2_resumed_r;
    out_data.drop_total    = s2_drops_r;
  end

  a_blocked_drops: assert property (@(posedge clk) disable iff (!rst_n)
    blocked_r == (drop_r != 32'd0))
    else $error("blocked flag and drop count disagree");

  a_payload_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == frx_pkg::PH_PAYLOAD) |-> (rem_r != '0))
    else $error("payload phase with nothing remaining");

  a_write_outside: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> ((wptr_r - tail_r) >= (head_r - tail_r)))
    else $error("payload write into committed bytes");

  a_resume_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && resumed) |=> (s2_status_r == frx_pkg::ST_ACCEPT && s2_drops_r != 32'd0))
    else $error("resume without an accepted packet");

endmodule

>>> rtl/framed_packet_rx_ring_buffer.sv
// Requests pass the front request queue, then the back end's result register.
// Throughput: one request per cycle while out_stall is low; at most one RAM access each.
// The two-entry request queue between front and back absorbs output stalls.
// Reset (rst_n low, synchronous) clears pointers, parser, drop count and queues;
// ring contents stay undefined and need no clearing pass.
// Top level; depends on frx_pkg, frx_front, frx_back (which holds frx_ram).
module framed_packet_rx_ring_buffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  frx_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output frx_pkg::out_item_t out_data
);

  logic         q_valid;
  logic         q_pop;
  frx_pkg::op_t q_op;

  frx_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_valid (q_valid),
    .q_op    (q_op),
    .q_pop   (q_pop)
  );

  frx_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_op     (q_op),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule

>>> test/framed_packet_rx_ring_buffer_test.sv
// Self-checking testbench for framed_packet_rx_ring_buffer: a scoreboard class predicts
// each reply from the requests taken; tasks drive requests, an always block out_stall.
// Depends on frx_pkg and the block's RTL.
module framed_packet_rx_ring_buffer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import frx_pkg::*;

  localparam logic [1:0] CMD_NONE = 2'd3;  // unused code, no operation
  localparam int PHASE_ITEMS = 200;

  class rx_ring_scoreboard;
    out_item_t        expected_replies[$];
    int unsigned      error_count;
    logic [7:0]       ring_bytes[RING_DEPTH];
    logic [PTR_W-1:0] head_ptr;
    logic [PTR_W-1:0] tail_ptr;
    logic [PTR_W-1:0] wr_ptr;
    logic [10:0]      bytes_left;
    phase_t           phase;
    logic [7:0]       len_lo;
    logic [15:0]      pkt_len;
    logic [31:0]      drop_count;
    logic             blocked_flag;

    function new();
      error_count  = 0;
      head_ptr     = '0;
      tail_ptr     = '0;
      wr_ptr       = '0;
      bytes_left   = '0;
      phase        = PH_IDLE;
      len_lo       = '0;
      pkt_len      = '0;
      drop_count   = '0;
      blocked_flag = 1'b0;
    endfunction

    // pointers are PTR_W wide, so the difference wraps with the ring
    function logic [PTR_W-1:0] fill();
      return head_ptr - tail_ptr;
    endfunction

    function void note_request(in_item_t req);
      out_item_t rsp;
      logic      resume;
      rsp    = '0;
      resume = 1'b0;
      if (req.command == CMD_POP) begin
        if (head_ptr != tail_ptr) begin
          rsp.read_data  = ring_bytes[tail_ptr];
          rsp.read_valid = 1'b1;
          tail_ptr++;
        end
      end else if (req.command == CMD_FLUSH) begin
        tail_ptr = head_ptr;
      end else if (req.command == CMD_FRAME) begin
        if (req.frame_start) begin
          // drop any header or payload in progress
          bytes_left = '0;
          if (req.rx_byte == SIG_BYTE) begin
            phase = PH_LEN_LO;
          end else begin
            phase = PH_IDLE;
            rsp.packet_status = ST_BAD_SIG;
          end
        end else begin
          case (phase)
            PH_LEN_LO: begin
              len_lo = req.rx_byte;
              phase  = PH_LEN_HI;
            end
            PH_LEN_HI: begin
              pkt_len = {req.rx_byte, len_lo};
              phase   = PH_SIG2;
            end
            PH_SIG2: begin
              phase = PH_IDLE;
              if (req.rx_byte != SIG_BYTE) begin
                rsp.packet_status = ST_BAD_SIG;
              end else if (pkt_len == 0 || pkt_len > RING_DEPTH - HDR_SIZE ||
                           pkt_len > FRAME_BYTES - HDR_SIZE) begin
                rsp.packet_status = ST_BAD_LEN;
              end else if (int'(pkt_len) < RING_DEPTH - int'(fill())) begin
                wr_ptr     = head_ptr;
                bytes_left = pkt_len[10:0];
                phase      = PH_PAYLOAD;
              end else begin
                if (drop_count != '1) drop_count++;
                blocked_flag      = 1'b1;
                rsp.packet_status = ST_DROPPED;
              end
            end
            PH_PAYLOAD: begin
              ring_bytes[wr_ptr] = req.rx_byte;
              wr_ptr++;
              if (bytes_left != 0) bytes_left--;
              if (bytes_left == 0) begin
                // commit the payload
                head_ptr          = wr_ptr;
                phase             = PH_IDLE;
                rsp.packet_status = ST_ACCEPT;
                if (blocked_flag) begin
                  resume       = 1'b1;
                  blocked_flag = 1'b0;
                end
              end
            end
            default: ;
          endcase
        end
      end
      rsp.fill_level = fill();
      rsp.blocked    = blocked_flag;
      rsp.resumed    = resume;
      rsp.drop_total = drop_count;
      if (resume) drop_count = '0;
      expected_replies.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        error_count++;
        $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      end
    endfunction

    function void check_reply(out_item_t got);
      out_item_t want;
      if (expected_replies.size() == 0) begin
        error_count++;
        $display("%0t: reply expected none actual %h", $time, got);
        return;
      end
      want = expected_replies.pop_front();
      compare_field("read_data", 32'(want.read_data), 32'(got.read_data));
      compare_field("read_valid", 32'(want.read_valid), 32'(got.read_valid));
      compare_field("fill_level", 32'(want.fill_level), 32'(got.fill_level));
      compare_field("packet_status", 32'(want.packet_status), 32'(got.packet_status));
      compare_field("blocked", 32'(want.blocked), 32'(got.blocked));
      compare_field("resumed", 32'(want.resumed), 32'(got.resumed));
      compare_field("drop_total", want.drop_total, got.drop_total);
    endfunction
  endclass

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  int idle_pct      = 0;
  int stall_pct     = 0;
  int requests_sent = 0;
  rx_ring_scoreboard sb;

  framed_packet_rx_ring_buffer uut (
    .clk,
    .rst_n,
    .in_valid,
    .in_stall,
    .in_data,
    .out_valid,
    .out_stall,
    .out_data
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_reply(out_data);
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  task automatic send_request(in_item_t req, bit counts = 1'b1);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(0, 99) < idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    if (counts) requests_sent++;
  endtask

  task automatic send_byte(logic [7:0] value, logic start, bit counts = 1'b1);
    in_item_t req;
    req.command     = CMD_FRAME;
    req.rx_byte     = value;
    req.frame_start = start;
    send_request(req, counts);
  endtask

  task automatic send_command(logic [1:0] cmd, bit counts = 1'b1);
    in_item_t req;
    req.command     = cmd;
    req.rx_byte     = 8'($urandom_range(0, 255));
    req.frame_start = 1'($urandom_range(0, 1));
    send_request(req, counts);
  endtask

  task automatic send_header(logic [15:0] len, logic [7:0] sig2);
    send_byte(SIG_BYTE, 1'b1);
    send_byte(len[7:0], 1'b0);
    send_byte(len[15:8], 1'b0);
    send_byte(sig2, 1'b0);
  endtask

  // send_count below len leaves the packet open for the next frame start to abandon
  task automatic send_packet(int len, int send_count);
    send_header(len[15:0], SIG_BYTE);
    for (int i = 0; i < send_count; i++) begin
      if ($urandom_range(0, 19) == 0) send_command(CMD_POP);
      if ($urandom_range(0, 199) == 0) send_command(CMD_FLUSH);
      send_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic random_step();
    int pick;
    int roll;
    int len;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      roll = $urandom_range(0, 99);
      if (roll < 88) len = $urandom_range(1, 16);
      else if (roll < 98) len = $urandom_range(17, 200);
      else len = $urandom_range(300, LEN_MAX);
      send_packet(len, ($urandom_range(0, 19) == 0) ? int'($urandom_range(0, len - 1)) : len);
    end else if (pick < 75) begin
      repeat ($urandom_range(1, 8)) send_command(CMD_POP);
    end else if (pick < 76) begin
      send_command(CMD_FLUSH);
    end else if (pick < 86) begin
      case ($urandom_range(0, 5))
        0: send_byte(8'($urandom_range(0, 254)), 1'b1);
        1: send_header(16'($urandom_range(1, LEN_MAX)), 8'($urandom_range(0, 254)));
        2: send_header(16'd0, SIG_BYTE);
        3: send_header(16'($urandom_range(LEN_MAX + 1, RING_DEPTH - 1)), SIG_BYTE);
        4: send_header(16'($urandom_range(LEN_MAX + 1, 16'hFFFF)), SIG_BYTE);
        default: begin
          send_byte(SIG_BYTE, 1'b1);
          if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)), 1'b0);
        end
      endcase
    end else if (pick < 94) begin
      if ($urandom_range(0, 1)) send_command(CMD_NONE, 1'b0);
      else send_byte(8'($urandom_range(0, 255)), 1'b0, sb.phase != PH_IDLE);
    end else begin
      send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  // lower valid and hold until every reply is back
  task automatic hold_off();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_replies.size() != 0) @(posedge clk);
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_command(CMD_POP);                       // pop on an empty ring
    send_byte(8'h5A, 1'b0, 1'b0);                // stray byte while idle
    send_command(CMD_NONE, 1'b0);
    send_byte(8'h00, 1'b1);                      // bad leading signature
    send_header(16'd1, 8'hFE);                   // bad trailing signature
    send_header(16'd0, SIG_BYTE);                // zero length
    send_header(16'(LEN_MAX + 1), SIG_BYTE);     // one past the longest payload
    send_byte(SIG_BYTE, 1'b1);                   // header cut short by a new frame
    send_byte(8'h02, 1'b0);
    send_header(16'd2, SIG_BYTE);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_command(CMD_POP);
    send_command(CMD_FLUSH);

    // longest payload into an empty ring, so the drop path opens early
    send_packet(LEN_MAX, LEN_MAX);

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 68; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 68; end
        default: begin idle_pct = 22; stall_pct = 22; end
      endcase
      requests_sent = 0;
      while (requests_sent < PHASE_ITEMS) random_step();
      hold_off();
    end

    repeat (6) @(posedge clk);
    if (sb.error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
rtl/frx_pkg.sv
rtl/frx_ram.sv
rtl/frx_front.sv
rtl/frx_back.sv
rtl/framed_packet_rx_ring_buffer.sv
test/framed_packet_rx_ring_buffer_test.sv
